// File: hw/rtl/mqf_pkg.sv
package mqf_pkg;

    localparam int DEF_QUEUE_COUNT = 4;
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_ENTRY_WIDTH = 16;

    localparam int CAP_REGS   = 4;
    localparam int QID_W      = 4;
    localparam int VAL_W      = 16;
    localparam int STATUS_W   = 2;
    localparam int ACTIVE_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP_BASE = 3'd1;

    typedef enum logic {
        OP_POST   = 1'b0,
        OP_ACCEPT = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_BAD_ID = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

endpackage

// File: hw/rtl/mqf_ptr_ram.sv
module mqf_ptr_ram #(
    parameter int DEPTH = 4,
    parameter int AW    = 2,
    parameter int DW    = 13
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata
);

    logic [DW-1:0] mem_reg [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [DW-1:0] rdata_reg;
    logic          rvld_reg;

    // entries never written since reset read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end else begin
            if (we) begin
                vld_reg[waddr] <= 1'b1;
            end
            if (re) begin
                rvld_reg <= vld_reg[raddr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rvld_reg ? rdata_reg : '0;

endmodule

// File: hw/rtl/mqf_entry_ram.sv
module mqf_entry_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 16
) (
    input  logic          aclk,
    input  logic          we,
    input  logic          re,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem_reg [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/multi_queue_fifo_manager.sv
// Channel  Dir  tdata                                   tuser
// s_       in   qid[3:0], entry_value[19:4]             op[0]
// m_       out  read_value[15:0]                        status[1:0]
// cfg_     in   cfg_addr = register index, cfg_wdata = value (no handshake)
//
// Each word goes through pointer memory read, pointer update with entry
// memory access, then the result moves to the output register.
// The next word is taken once the result sits in the output register.
// Reset is synchronous; per-queue valid bits clear the pointers at once.
// A stalled m_ side holds the engine in its last step until the register frees.
module multi_queue_fifo_manager #(
    parameter int QUEUE_COUNT = mqf_pkg::DEF_QUEUE_COUNT,
    parameter int QUEUE_DEPTH = mqf_pkg::DEF_QUEUE_DEPTH,
    parameter int ENTRY_WIDTH = mqf_pkg::DEF_ENTRY_WIDTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mqf_pkg::IN_DATA_W-1:0]    s_tdata,   // qid, entry_value
    input  logic [0:0]                       s_tuser,   // op
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mqf_pkg::OUT_DATA_W-1:0]   m_tdata,   // read_value
    output logic [mqf_pkg::STATUS_W-1:0]     m_tuser,   // status
    input  logic                             cfg_we,
    input  logic [mqf_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [mqf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    import mqf_pkg::*;

    localparam int PQ_W   = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int PTR_W  = CNT_W + 2 * IDX_W;
    localparam int ENT_N  = QUEUE_COUNT * QUEUE_DEPTH;
    localparam int ADDR_W = $clog2(ENT_N);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FINISH
    } state_t;

    state_t                  state_reg;
    op_t                     op_reg;
    logic [QID_W-1:0]        qid_reg;
    logic [PQ_W-1:0]         qidx_reg;
    logic [VAL_W-1:0]        val_reg;
    status_t                 status_reg;
    logic                    hit_reg;
    logic                    m_tvalid_reg;
    logic [OUT_DATA_W-1:0]   m_tdata_reg;
    status_t                 m_tuser_reg;
    logic [ACTIVE_W-1:0]     active_reg;
    logic [CNT_W-1:0]        cap_reg [QUEUE_COUNT];

    logic                    accept;
    logic [QID_W-1:0]        s_qid;
    logic [VAL_W-1:0]        s_val;
    logic [PQ_W-1:0]         ptr_raddr;
    logic [PTR_W-1:0]        ptr_rdata;
    logic                    ptr_we;
    logic [PQ_W-1:0]         ptr_waddr;
    logic [PTR_W-1:0]        ptr_wdata;

    logic [CNT_W-1:0]        cnt;
    logic [IDX_W-1:0]        rd_idx;
    logic [IDX_W-1:0]        wr_idx;
    logic [CNT_W-1:0]        cap_sel;
    logic [CNT_W:0]          rd_inc;
    logic [CNT_W:0]          wr_inc;
    logic [IDX_W-1:0]        rd_nx;
    logic [IDX_W-1:0]        wr_nx;
    logic [CNT_W-1:0]        cnt_next;
    logic [PTR_W-1:0]        ptr_next;
    logic                    bad;
    logic                    is_post;
    logic                    full;
    logic                    empty;
    logic                    do_post;
    logic                    do_take;
    status_t                 status_next;

    logic [ADDR_W-1:0]       e_base;
    logic [ADDR_W-1:0]       e_addr;
    logic                    e_we;
    logic                    e_re;
    logic [ENTRY_WIDTH+VAL_W-1:0] e_wext;
    logic [ENTRY_WIDTH-1:0]  e_wdata;
    logic [ENTRY_WIDTH-1:0]  e_rdata;
    logic [ENTRY_WIDTH+OUT_DATA_W-1:0] e_rext;
    logic                    out_free;

    logic                    cfg_cap_hit;
    logic                    cfg_clear;
    logic [CFG_IDX_W-1:0]    cfg_q;
    logic [QID_W-1:0]        cfg_q_ext;
    logic [CNT_W-1:0]        cap_sat;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign s_qid    = s_tdata[QID_W-1:0];
    assign s_val    = s_tdata[QID_W +: VAL_W];
    assign ptr_raddr = (s_qid < QID_W'(QUEUE_COUNT)) ? s_qid[PQ_W-1:0] : '0;

    // config decode
    assign cfg_q       = cfg_addr - CFG_CAP_BASE;
    assign cfg_q_ext   = QID_W'(cfg_q);
    assign cfg_cap_hit = cfg_we && (cfg_addr >= CFG_CAP_BASE)
                         && (int'(cfg_addr) < int'(CFG_CAP_BASE) + CAP_REGS);
    assign cfg_clear   = cfg_cap_hit && (int'(cfg_q) < QUEUE_COUNT);
    assign cap_sat     = (int'(cfg_wdata) > QUEUE_DEPTH) ? CNT_W'(QUEUE_DEPTH)
                                                         : CNT_W'(cfg_wdata);

    // pointer record: {count, read index, write index}
    assign cnt     = ptr_rdata[PTR_W-1 -: CNT_W];
    assign rd_idx  = ptr_rdata[IDX_W +: IDX_W];
    assign wr_idx  = ptr_rdata[IDX_W-1:0];
    assign cap_sel = cap_reg[qidx_reg];

    assign rd_inc = (CNT_W+1)'(rd_idx) + 1'b1;
    assign wr_inc = (CNT_W+1)'(wr_idx) + 1'b1;
    assign rd_nx  = (rd_inc >= (CNT_W+1)'(cap_sel)) ? '0 : rd_inc[IDX_W-1:0];
    assign wr_nx  = (wr_inc >= (CNT_W+1)'(cap_sel)) ? '0 : wr_inc[IDX_W-1:0];

    assign bad     = (qid_reg >= QID_W'(QUEUE_COUNT)) || (qid_reg >= QID_W'(active_reg));
    assign is_post = (op_reg == OP_POST);
    assign full    = (cnt >= cap_sel);
    assign empty   = (cnt == '0);
    assign do_post = !bad && is_post && !full;
    assign do_take = !bad && !is_post && !empty;

    always_comb begin
        if (bad) begin
            status_next = ST_BAD_ID;
        end else if (is_post) begin
            status_next = full ? ST_FULL : ST_OK;
        end else begin
            status_next = empty ? ST_EMPTY : ST_OK;
        end
    end

    always_comb begin
        if (do_post) begin
            cnt_next = cnt + 1'b1;
        end else if (do_take) begin
            cnt_next = cnt - 1'b1;
        end else begin
            cnt_next = cnt;
        end
    end

    assign ptr_next  = {cnt_next, (do_take ? rd_nx : rd_idx), (do_post ? wr_nx : wr_idx)};
    assign ptr_we    = cfg_clear || ((state_reg == S_EXEC) && (do_post || do_take));
    assign ptr_waddr = cfg_clear ? cfg_q_ext[PQ_W-1:0] : qidx_reg;
    assign ptr_wdata = cfg_clear ? '0 : ptr_next;

    // entry store access
    assign e_base  = ADDR_W'(ADDR_W'(qidx_reg) * ADDR_W'(QUEUE_DEPTH));
    assign e_addr  = e_base + ADDR_W'(is_post ? wr_idx : rd_idx);
    assign e_we    = (state_reg == S_EXEC) && do_post;
    assign e_re    = (state_reg == S_EXEC) && do_take;
    assign e_wext  = {{ENTRY_WIDTH{1'b0}}, val_reg};
    assign e_wdata = e_wext[ENTRY_WIDTH-1:0];
    assign e_rext  = {{OUT_DATA_W{1'b0}}, e_rdata};

    assign out_free = !m_tvalid_reg || m_tready;

    mqf_ptr_ram #(
        .DEPTH (QUEUE_COUNT),
        .AW    (PQ_W),
        .DW    (PTR_W)
    ) u_ptr_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .re      (accept),
        .raddr   (ptr_raddr),
        .rdata   (ptr_rdata),
        .we      (ptr_we),
        .waddr   (ptr_waddr),
        .wdata   (ptr_wdata)
    );

    mqf_entry_ram #(
        .DEPTH (ENT_N),
        .AW    (ADDR_W),
        .DW    (ENTRY_WIDTH)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (e_we),
        .re    (e_re),
        .addr  (e_addr),
        .wdata (e_wdata),
        .rdata (e_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            active_reg   <= '0;
            for (int i = 0; i < QUEUE_COUNT; i++) begin
                cap_reg[i] <= '0;
            end
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        op_reg    <= op_t'(s_tuser[0]);
                        qid_reg   <= s_qid;
                        qidx_reg  <= ptr_raddr;
                        val_reg   <= s_val;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    status_reg <= status_next;
                    hit_reg    <= do_take;
                    state_reg  <= S_FINISH;
                end
                S_FINISH: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= hit_reg ? e_rext[OUT_DATA_W-1:0] : '0;
                        m_tuser_reg  <= status_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (cfg_we && (cfg_addr == CFG_ACTIVE)) begin
                active_reg <= cfg_wdata[ACTIVE_W-1:0];
            end
            for (int i = 0; i < QUEUE_COUNT; i++) begin
                if (cfg_clear && (cfg_q_ext == QID_W'(i))) begin
                    cap_reg[i] <= cap_sat;
                end
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: tb/mqf_queue_checker.sv
`timescale 1ns / 1ps
module mqf_queue_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [mqf_pkg::IN_DATA_W-1:0]       s_tdata,   // qid, entry_value
    input  logic [0:0]                          s_tuser,   // op
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [mqf_pkg::OUT_DATA_W-1:0]      m_tdata,   // read_value
    input  logic [mqf_pkg::STATUS_W-1:0]        m_tuser,   // status
    input  logic                                cfg_we,
    input  logic [mqf_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [mqf_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    output int                                  mismatches,
    output int                                  replies_owed
);

    import mqf_pkg::*;

    localparam int NQ    = DEF_QUEUE_COUNT;
    localparam int DEPTH = DEF_QUEUE_DEPTH;

    typedef struct packed {
        status_t               status;
        logic [VAL_W-1:0]      value;
    } reply_t;

    logic [VAL_W-1:0] entry_mem [NQ*DEPTH];
    int fill [NQ];
    int rd_ptr [NQ];
    int wr_ptr [NQ];
    int cap [NQ];
    int active_cnt;
    int fail_tally = 0;
    reply_t predicted_replies [$];

    assign mismatches = fail_tally;

    function automatic int ring_step(input int idx, input int limit);
        return (idx + 1 >= limit) ? 0 : idx + 1;
    endfunction

    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        int q;
        int c;
        if (idx == CFG_ACTIVE) begin
            active_cnt = int'(data[ACTIVE_W-1:0]);
        end else if (idx >= CFG_CAP_BASE && idx < CFG_CAP_BASE + CAP_REGS) begin
            q = int'(idx - CFG_CAP_BASE);
            c = int'(data);
            if (q < NQ) begin
                cap[q] = (c > DEPTH) ? DEPTH : c;
                fill[q] = 0;
                rd_ptr[q] = 0;
                wr_ptr[q] = 0;
            end
        end
    endfunction

    function automatic reply_t apply_queue_op(input op_t op, input int q,
                                              input logic [VAL_W-1:0] val);
        reply_t r;
        int eff;
        r.status = ST_OK;
        r.value  = '0;
        eff = (active_cnt < NQ) ? active_cnt : NQ;
        if (q >= eff) begin
            r.status = ST_BAD_ID;
        end else if (op == OP_POST) begin
            if (fill[q] >= cap[q]) begin
                r.status = ST_FULL;
            end else begin
                entry_mem[q*DEPTH + wr_ptr[q]] = val;
                fill[q]++;
                wr_ptr[q] = ring_step(wr_ptr[q], cap[q]);
            end
        end else begin
            if (fill[q] == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.value = entry_mem[q*DEPTH + rd_ptr[q]];
                fill[q]--;
                rd_ptr[q] = ring_step(rd_ptr[q], cap[q]);
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        reply_t want;
        reply_t got;
        if (!aresetn) begin
            for (int q = 0; q < NQ; q++) begin
                fill[q] = 0;
                rd_ptr[q] = 0;
                wr_ptr[q] = 0;
                cap[q] = 0;
            end
            active_cnt = 0;
            predicted_replies.delete();
            replies_owed <= 0;
        end else begin
            if (cfg_we)
                apply_reg_write(cfg_addr, cfg_wdata);
            // check before push: a word never leaves in the cycle it enters
            if (m_tvalid && m_tready) begin
                got.status = status_t'(m_tuser);
                got.value  = m_tdata;
                if (predicted_replies.size() == 0) begin
                    $display("%0t: unexpected word, expected none, got status %0d value %h",
                             $time, m_tuser, m_tdata);
                    fail_tally++;
                end else begin
                    want = predicted_replies.pop_front();
                    if (want.status !== got.status || want.value !== got.value) begin
                        $display("%0t: mismatch, expected status %0d value %h,",
                                 $time, want.status, want.value);
                        $display("    got status %0d value %h", m_tuser, m_tdata);
                        fail_tally++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predicted_replies.push_back(apply_queue_op(op_t'(s_tuser[0]),
                                                           int'(s_tdata[3:0]), s_tdata[19:4]));
            replies_owed <= predicted_replies.size();
        end
    end

endmodule

// File: tb/tb_multi_queue_fifo_manager.sv
`timescale 1ns / 1ps
module tb_multi_queue_fifo_manager;

    import mqf_pkg::*;

    localparam int NQ            = DEF_QUEUE_COUNT;
    localparam int DEPTH         = DEF_QUEUE_DEPTH;
    localparam int SETTLE_CYCLES = 8;
    localparam int CHUNKS        = 15;
    localparam int CHUNK_WORDS   = 100;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata = '0;    // qid[3:0], entry_value[19:4]
    logic [0:0]              s_tuser = '0;    // op
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_tdata;         // read_value[15:0]
    logic [STATUS_W-1:0]     m_tuser;         // status[1:0]
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_addr = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

    int mismatches;
    int replies_owed;
    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    int words_sent = 0;
    int settings_applied = 0;
    int active_setting = 0;

    always #4 aclk = ~aclk;

    multi_queue_fifo_manager DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    mqf_queue_checker reply_monitor (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .mismatches   (mismatches),
        .replies_owed (replies_owed)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    task automatic send_word(input op_t op, input int qid, input logic [VAL_W-1:0] val);
        if ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < sender_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, val, qid[3:0]};
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    task automatic drain_replies();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (replies_owed != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // leaves cfg_we high; caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val[CFG_DATA_W-1:0];
        @(posedge aclk);
        if (idx == CFG_ACTIVE)
            active_setting = val & 7;
    endtask

    function automatic int pick_capacity();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10) return 0;
        if (roll < 35) return $urandom_range(1, 4);
        if (roll < 60) return DEPTH;
        if (roll < 75) return $urandom_range(DEPTH + 1, 31);
        return $urandom_range(DEPTH);
    endfunction

    task automatic send_random_word(input int post_pct);
        int eff;
        int qid;
        op_t op;
        eff = (active_setting < NQ) ? active_setting : NQ;
        if (eff > 0 && $urandom_range(99) < 90)
            qid = $urandom_range(eff - 1);
        else
            qid = $urandom_range(15);
        op = ($urandom_range(99) < post_pct) ? OP_POST : OP_ACCEPT;
        send_word(op, qid, 16'($urandom));
    endtask

    initial begin
        int post_pct;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // nothing active out of reset
        send_word(OP_POST, 0, 16'h1234);
        drain_replies();

        write_reg(CFG_ACTIVE, 4);
        write_reg(CFG_CAP_BASE + 3'd0, 1);
        write_reg(CFG_CAP_BASE + 3'd1, DEPTH);
        write_reg(CFG_CAP_BASE + 3'd2, 0);
        write_reg(CFG_CAP_BASE + 3'd3, 25);   // saturates
        write_reg(3'd5, 31);
        write_reg(3'd7, 0);
        cfg_we <= 1'b0;
        settings_applied++;

        send_word(OP_POST, 0, 16'hFFFF);
        send_word(OP_POST, 0, 16'h0001);
        send_word(OP_ACCEPT, 0, 16'h0000);
        send_word(OP_ACCEPT, 0, 16'hFFFF);
        send_word(OP_POST, 2, 16'hAAAA);
        send_word(OP_ACCEPT, 2, 16'h0000);
        send_word(OP_POST, 1, 16'h0000);
        send_word(OP_POST, 1, 16'h5555);
        send_word(OP_ACCEPT, 1, 16'h0000);
        send_word(OP_ACCEPT, 1, 16'h0000);
        send_word(OP_POST, 15, 16'hFFFF);
        send_word(OP_ACCEPT, 4, 16'h0000);
        send_word(OP_POST, 3, 16'h8001);
        send_word(OP_POST, 3, 16'h7FFE);
        drain_replies();

        // active count above the queue count; contents must survive
        write_reg(CFG_ACTIVE, 7);
        cfg_we <= 1'b0;
        send_word(OP_ACCEPT, 3, 16'h0000);
        send_word(OP_ACCEPT, 4, 16'h0000);
        drain_replies();

        write_reg(CFG_ACTIVE, 2);
        cfg_we <= 1'b0;
        send_word(OP_ACCEPT, 3, 16'h0000);
        drain_replies();

        // capacity write empties the queue; small ring wraps
        write_reg(CFG_ACTIVE, 4);
        write_reg(CFG_CAP_BASE + 3'd1, 3);
        write_reg(CFG_CAP_BASE + 3'd3, 1);
        cfg_we <= 1'b0;
        settings_applied++;
        send_word(OP_ACCEPT, 3, 16'h0000);
        for (int i = 1; i <= 3; i++)
            send_word(OP_POST, 1, 16'(i * 16'h1111));
        send_word(OP_POST, 1, 16'hDEAD);
        send_word(OP_ACCEPT, 1, 16'h0000);
        send_word(OP_ACCEPT, 1, 16'h0000);
        send_word(OP_POST, 1, 16'hBEEF);
        send_word(OP_POST, 1, 16'hCAFE);
        for (int i = 0; i < 3; i++)
            send_word(OP_ACCEPT, 1, 16'h0000);
        drain_replies();

        for (int chunk = 0; chunk < CHUNKS; chunk++) begin
            case (chunk / 5)
                0: begin
                    sender_idle_pct   = 7;
                    receiver_idle_pct = 53;
                end
                1: begin
                    sender_idle_pct   = 53;
                    receiver_idle_pct = 7;
                end
                default: begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            if ($urandom_range(3) == 0)
                write_reg(CFG_ACTIVE, $urandom_range(7));
            else
                write_reg(CFG_ACTIVE, $urandom_range(3, 4));
            for (int q = 0; q < NQ; q++)
                if ($urandom_range(99) < 70)
                    write_reg(CFG_CAP_BASE + 3'(q), pick_capacity());
            if ($urandom_range(4) == 0)
                write_reg(3'($urandom_range(5, 7)), $urandom_range(31));
            cfg_we <= 1'b0;
            settings_applied++;
            post_pct = $urandom_range(30, 70);
            repeat (CHUNK_WORDS) send_random_word(post_pct);
            drain_replies();
        end

        $display("Covered %0d words over %0d register settings,", words_sent, settings_applied);
        $display("with sender-heavy, receiver-heavy and stall-free traffic.");
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #5000000;
        $display("Timeout with %0d words still owed", replies_owed);
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/mqf_pkg.sv
hw/rtl/mqf_ptr_ram.sv
hw/rtl/mqf_entry_ram.sv
hw/rtl/multi_queue_fifo_manager.sv
tb/mqf_queue_checker.sv
tb/tb_multi_queue_fifo_manager.sv
